FILE: design/rcsf_pkg.sv
package rcsf_pkg;

  localparam int DEF_FRAME_BYTES = 25;
  localparam int DEF_CHANNELS    = 12;

  localparam logic [7:0] HEADER_BYTE = 8'h0F;
  localparam int DATA_BYTES      = 17;
  localparam int DATA_BITS       = DATA_BYTES * 8;
  localparam int RAW_W           = 11;
  localparam int VAL_W           = 12;
  localparam int PROD_W          = 27;
  localparam int SUM_W           = 28;
  localparam int OFFSET_CHANNELS = 7;
  localparam int ARM_CHANNEL     = 8;
  localparam int NUM_W           = 4;

  localparam logic [15:0]      SCALE_MUL = 16'd58514;
  localparam logic [SUM_W-1:0] SCALE_ADD = 28'd38384435;
  localparam logic [VAL_W-1:0] ARM_THRESHOLD_RESET = 12'd1300;

  typedef logic [RAW_W-1:0] raw_t;
  typedef logic [VAL_W-1:0] val_t;
  typedef logic [PROD_W-1:0] prod_t;

  // First half of the microsecond scaling: the constant product.
  function automatic prod_t scale_mul(input raw_t raw);
    logic [RAW_W+15:0] p;
    p = raw * SCALE_MUL;
    return PROD_W'(p);
  endfunction

  // Second half: add the rounding offset and drop the 16 fraction bits.
  function automatic val_t scale_fin(input prod_t prod);
    logic [SUM_W-1:0] s;
    s = SUM_W'(prod) + SCALE_ADD;
    return s[16 +: VAL_W];
  endfunction

endpackage

FILE: design/rcsf_cell.sv
module rcsf_cell (
  input  logic                clk,
  input  logic                load,
  input  logic                shift,
  input  rcsf_pkg::raw_t      load_d,
  input  rcsf_pkg::raw_t      shift_d,
  output rcsf_pkg::raw_t      q
);
  import rcsf_pkg::*;

  raw_t raw_r;
  raw_t raw_nxt;

  always_comb begin
    raw_nxt = raw_r;
    if (load) begin
      raw_nxt = load_d;
    end else if (shift) begin
      raw_nxt = shift_d;
    end
  end

  always_ff @(posedge clk) begin
    raw_r <= raw_nxt;
  end

  assign q = raw_r;

endmodule

FILE: design/rcsf_collector.sv
module rcsf_collector #(
  parameter int FRAME_BYTES = rcsf_pkg::DEF_FRAME_BYTES
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [7:0]                     in_rx_byte,
  input  logic                           hold,
  output logic                           in_stall,
  output logic                           frame_load,
  output logic [rcsf_pkg::DATA_BITS-1:0] frame_bits
);
  import rcsf_pkg::*;

  localparam int PW = $clog2(FRAME_BYTES);
  localparam logic [PW-1:0] LAST_POS = PW'(FRAME_BYTES - 1);

  logic                 collecting_r, collecting_nxt;
  logic [PW-1:0]        pos_r, pos_nxt;
  logic [DATA_BITS-1:0] bytes_r, bytes_nxt;
  logic                 accept;
  logic                 at_last;

  assign at_last  = collecting_r && (pos_r == LAST_POS);
  // The closing byte of a frame waits until the previous frame has drained.
  assign in_stall = hold && at_last;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    collecting_nxt = collecting_r;
    pos_nxt        = pos_r;
    bytes_nxt      = bytes_r;
    frame_load     = 1'b0;
    if (accept) begin
      if (!collecting_r) begin
        if (in_rx_byte == HEADER_BYTE) begin
          collecting_nxt = 1'b1;
          pos_nxt        = PW'(1);
        end
      end else begin
        if (32'(pos_r) <= DATA_BYTES) begin
          bytes_nxt = {in_rx_byte, bytes_r[DATA_BITS-1:8]};
        end
        if (at_last) begin
          collecting_nxt = 1'b0;
          pos_nxt        = '0;
          frame_load     = 1'b1;
        end else begin
          pos_nxt = pos_r + PW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collecting_r <= 1'b0;
      pos_r        <= '0;
    end else begin
      collecting_r <= collecting_nxt;
      pos_r        <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
  end

  // The first data byte ends up in the low bits, giving the little-endian stream.
  assign frame_bits = bytes_nxt;

endmodule

FILE: design/rc_serial_frame_channel_decoder.sv
// Serial RC frame decoder. Bytes are taken one per cycle unless stalled; a
// frame starts at a 0x0F header byte and closes after FRAME_BYTES bytes by
// count. On the closing byte the eleven-bit channels are loaded in parallel
// into a row of channel cells, and after a check of channel 8 against
// arm_threshold (states ARM_MUL, then ARM_CMP) the row shifts one channel per
// cycle, unless out_stall holds it, into a two-stage scaling pipeline, so a
// frame yields CHANNELS words, channel 1 first. The closing byte of the next
// frame is held off with in_stall until the previous frame has left the
// cell row and scaling stage. arm_threshold must only be written while idle.
module rc_serial_frame_channel_decoder #(
  parameter int FRAME_BYTES = rcsf_pkg::DEF_FRAME_BYTES,
  parameter int CHANNELS    = rcsf_pkg::DEF_CHANNELS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rcsf_pkg::VAL_W-1:0] cfg_arm_threshold,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_rx_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [rcsf_pkg::NUM_W-1:0] out_channel_number,
  output logic [rcsf_pkg::VAL_W-1:0] out_channel_value,
  output logic [rcsf_pkg::VAL_W-1:0] out_captured_offset,
  output logic                       out_offset_valid,
  output logic                       out_last
);
  import rcsf_pkg::*;

  localparam int CH_BITS = CHANNELS * RAW_W;
  localparam int ALL_BITS = (CH_BITS > DATA_BITS) ? CH_BITS : DATA_BITS;
  localparam int IW = $clog2(CHANNELS + 1);
  localparam int CW = $clog2(CHANNELS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(CHANNELS - 1);

  localparam logic [1:0] ARM_IDLE = 2'd0;
  localparam logic [1:0] ARM_MUL  = 2'd1;
  localparam logic [1:0] ARM_CMP  = 2'd2;

  logic                 frame_load;
  logic [DATA_BITS-1:0] frame_bits;
  logic [ALL_BITS-1:0]  stream;
  logic                 busy;

  val_t thr_r;

  logic [1:0] arm_st_r, arm_st_nxt;
  raw_t       arm_raw_r;
  prod_t      arm_prod_r;
  logic       latched_r, latched_nxt;
  logic       latch_frame_r, latch_frame_nxt;

  raw_t          cell_q [CHANNELS];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          issue;

  logic          s1_v_r, s1_v_nxt;
  prod_t         s1_prod_r;
  logic [IW-1:0] s1_idx_r;
  logic          s1_go;
  logic          out_free;
  logic          s1_is_off;
  val_t          s1_val;
  val_t          s1_off;

  val_t offset_r [OFFSET_CHANNELS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= ARM_THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_arm_threshold;
    end
  end

  assign busy = (cnt_r != '0) || s1_v_r || (arm_st_r != ARM_IDLE);

  rcsf_collector #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_collector (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .hold       (busy),
    .in_stall   (in_stall),
    .frame_load (frame_load),
    .frame_bits (frame_bits)
  );

  // Bits past the data bytes read as zero.
  assign stream = ALL_BITS'(frame_bits);

  assign out_free = !out_valid || !out_stall;
  assign s1_go    = s1_v_r && out_free;
  assign issue    = (cnt_r != '0) && (arm_st_r == ARM_IDLE) && (!s1_v_r || s1_go);

  for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
    raw_t shift_d;
    if (i == CHANNELS - 1) begin : g_tail
      assign shift_d = '0;
    end else begin : g_mid
      assign shift_d = cell_q[i+1];
    end
    rcsf_cell u_cell (
      .clk     (clk),
      .load    (frame_load),
      .shift   (issue),
      .load_d  (stream[i*RAW_W +: RAW_W]),
      .shift_d (shift_d),
      .q       (cell_q[i])
    );
  end

  // Channel 8 decides the offset latch before channel 1 is scaled.
  always_comb begin
    arm_st_nxt      = arm_st_r;
    latched_nxt     = latched_r;
    latch_frame_nxt = latch_frame_r;
    unique case (arm_st_r)
      ARM_IDLE: begin
        if (frame_load) begin
          arm_st_nxt      = ARM_MUL;
          latch_frame_nxt = 1'b0;
        end
      end
      ARM_MUL: begin
        arm_st_nxt = ARM_CMP;
      end
      ARM_CMP: begin
        arm_st_nxt = ARM_IDLE;
        if (!latched_r && (scale_fin(arm_prod_r) >= thr_r)) begin
          latched_nxt     = 1'b1;
          latch_frame_nxt = 1'b1;
        end
      end
      default: begin
        arm_st_nxt = ARM_IDLE;
      end
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (frame_load) begin
      cnt_nxt = CW'(CHANNELS);
      idx_nxt = '0;
    end else if (issue) begin
      cnt_nxt = cnt_r - CW'(1);
      idx_nxt = idx_r + IW'(1);
    end
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (issue) begin
      s1_v_nxt = 1'b1;
    end else if (s1_go) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arm_st_r      <= ARM_IDLE;
      latched_r     <= 1'b0;
      latch_frame_r <= 1'b0;
      cnt_r         <= '0;
      idx_r         <= '0;
      s1_v_r        <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      arm_st_r      <= arm_st_nxt;
      latched_r     <= latched_nxt;
      latch_frame_r <= latch_frame_nxt;
      cnt_r         <= cnt_nxt;
      idx_r         <= idx_nxt;
      s1_v_r        <= s1_v_nxt;
      if (s1_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame_load) begin
      arm_raw_r <= stream[(ARM_CHANNEL-1)*RAW_W +: RAW_W];
    end
    if (arm_st_r == ARM_MUL) begin
      arm_prod_r <= scale_mul(arm_raw_r);
    end
    if (issue) begin
      s1_prod_r <= scale_mul(cell_q[0]);
      s1_idx_r  <= idx_r;
    end
  end

  assign s1_is_off = 32'(s1_idx_r) < OFFSET_CHANNELS;
  assign s1_val    = scale_fin(s1_prod_r);

  always_comb begin
    s1_off = '0;
    if (s1_is_off) begin
      s1_off = latch_frame_r ? s1_val : offset_r[3'(s1_idx_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < OFFSET_CHANNELS; k++) begin
        offset_r[k] <= '0;
      end
    end else if (s1_go && s1_is_off && latch_frame_r) begin
      offset_r[3'(s1_idx_r)] <= s1_val;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_channel_number  <= NUM_W'(32'(s1_idx_r) + 1);
      out_channel_value   <= s1_val;
      out_captured_offset <= s1_off;
      out_offset_valid    <= latched_r;
      out_last            <= (s1_idx_r == LAST_IDX);
    end
  end

endmodule

FILE: tb/tb_rc_serial_frame_channel_decoder.sv
module tb_rc_serial_frame_channel_decoder;
  import rcsf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCH        = DEF_CHANNELS;
  localparam int FRAME_LEN  = DEF_FRAME_BYTES;
  localparam int TAIL_BYTES = FRAME_LEN - 1 - DATA_BYTES;
  localparam int SETTLE     = 30;
  localparam int IDLE_LIMIT = 4000;

  typedef struct packed {
    logic [NUM_W-1:0] number;
    val_t             value;
    val_t             offset;
    logic             latched;
    logic             last;
  } chan_word_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  val_t cfg_arm_threshold = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [NUM_W-1:0] out_channel_number;
  val_t out_channel_value;
  val_t out_captured_offset;
  logic out_offset_valid;
  logic out_last;

  rc_serial_frame_channel_decoder dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_arm_threshold  (cfg_arm_threshold),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_channel_number (out_channel_number),
    .out_channel_value  (out_channel_value),
    .out_captured_offset(out_captured_offset),
    .out_offset_valid   (out_offset_valid),
    .out_last           (out_last)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Decoder shadow state.
  logic       dec_collecting = 1'b0;
  int         dec_position = 0;
  logic [7:0] dec_bytes [DATA_BYTES];
  val_t       dec_offsets [OFFSET_CHANNELS] = '{default: '0};
  logic       dec_latched = 1'b0;
  val_t       dec_threshold = ARM_THRESHOLD_RESET;

  logic [7:0] tx_bytes [$];
  chan_word_t due_words [$];

  logic in_taken = 1'b0;
  int   gap_left = 0;
  int   burst_left = 1;
  int   stall_left = 0;
  stall_mode_t stall_mode = STALL_NONE;

  int errors = 0;
  int bytes_taken = 0;
  int frames_closed = 0;
  int words_checked = 0;
  int idle_cycles = 0;

  function automatic val_t to_usec(input raw_t raw);
    logic [31:0] acc;
    acc = 32'(raw) * 32'd58514 + 32'd38384435;
    return acc[27:16];
  endfunction

  function automatic raw_t pick_raw();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return raw_t'($urandom);
    endcase
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    logic [DATA_BITS-1:0] bits;
    val_t vals [NCH];
    chan_word_t w;
    if (!dec_collecting) begin
      if (b == HEADER_BYTE) begin
        dec_collecting = 1'b1;
        dec_position = 1;
      end
      return;
    end
    if (dec_position <= DATA_BYTES) dec_bytes[dec_position-1] = b;
    if (dec_position < FRAME_LEN - 1) begin
      dec_position++;
      return;
    end
    dec_collecting = 1'b0;
    dec_position = 0;
    frames_closed++;
    for (int i = 0; i < DATA_BYTES; i++) bits[8*i +: 8] = dec_bytes[i];
    for (int k = 0; k < NCH; k++) vals[k] = to_usec(bits[RAW_W*k +: RAW_W]);
    // Offsets are captured once only, from the frame that first arms.
    if (!dec_latched && vals[ARM_CHANNEL-1] >= dec_threshold) begin
      for (int k = 0; k < OFFSET_CHANNELS; k++) dec_offsets[k] = vals[k];
      dec_latched = 1'b1;
    end
    for (int k = 0; k < NCH; k++) begin
      w.number  = NUM_W'(k + 1);
      w.value   = vals[k];
      w.offset  = (k < OFFSET_CHANNELS) ? dec_offsets[k] : '0;
      w.latched = dec_latched;
      w.last    = (k == NCH - 1);
      due_words.push_back(w);
    end
  endtask

  // Input and result handshakes, checking, and the watchdog.
  always @(posedge clk) begin
    chan_word_t got;
    chan_word_t want;
    logic busy;
    busy = 1'b0;
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) begin
      decode_byte(in_rx_byte);
      bytes_taken++;
      busy = 1'b1;
    end
    if (rst_n && cfg_valid && cfg_ready) busy = 1'b1;
    if (rst_n && out_valid && !out_stall) begin
      busy = 1'b1;
      got = '{out_channel_number, out_channel_value, out_captured_offset,
              out_offset_valid, out_last};
      if (due_words.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: ch %0d value %0d offset %0d valid %0b last %0b",
                   got.number, got.value, got.offset, got.latched, got.last);
      end else begin
        want = due_words.pop_front();
        words_checked++;
        if (got.number !== want.number || got.value !== want.value ||
            got.offset !== want.offset || got.latched !== want.latched ||
            got.last !== want.last) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: expected ch %0d value %0d offset %0d valid %0b last %0b",
                     want.number, want.value, want.offset, want.latched, want.last);
            $display("          got      ch %0d value %0d offset %0d valid %0b last %0b",
                     got.number, got.value, got.offset, got.latched, got.last);
          end
        end
      end
    end
    if (!rst_n || busy) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("tb_rc_serial_frame_channel_decoder: errors");
      $finish;
    end
  end

  // Byte sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    logic nv;
    nv = in_valid && !in_taken;
    if (rst_n && !nv) begin
      if (gap_left != 0) begin
        gap_left--;
      end else if (tx_bytes.size() != 0) begin
        in_rx_byte <= tx_bytes.pop_front();
        nv = 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = $urandom_range(0, 6);
        end else begin
          burst_left--;
        end
      end
    end
    in_valid <= nv;
  end

  // Result receiver: stall pattern switches between a few modes.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(5, 60);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
      STALL_PERIODIC: out_stall <= (stall_left % 3 == 0);
      default:        out_stall <= ($urandom_range(0, 5) != 0);
    endcase
  end

  task automatic write_threshold(input val_t v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_arm_threshold <= v;
    do @(posedge clk); while (!cfg_ready);
    dec_threshold = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (tx_bytes.size() != 0 || in_valid || due_words.size() != 0) @(posedge clk);
  endtask

  task automatic push_frame(input logic [NCH*RAW_W-1:0] raws, input logic [3:0] pad,
                            input logic [8*TAIL_BYTES-1:0] tail);
    logic [DATA_BITS-1:0] d;
    d = {pad, raws};
    tx_bytes.push_back(HEADER_BYTE);
    for (int i = 0; i < DATA_BYTES; i++) tx_bytes.push_back(d[8*i +: 8]);
    for (int i = 0; i < TAIL_BYTES; i++) tx_bytes.push_back(tail[8*i +: 8]);
  endtask

  function automatic logic [NCH*RAW_W-1:0] random_raws();
    logic [NCH*RAW_W-1:0] r;
    for (int k = 0; k < NCH; k++) r[RAW_W*k +: RAW_W] = pick_raw();
    return r;
  endfunction

  function automatic logic [8*TAIL_BYTES-1:0] random_tail();
    logic [8*TAIL_BYTES-1:0] t;
    for (int i = 0; i < TAIL_BYTES; i++)
      t[8*i +: 8] = ($urandom_range(0, 5) == 0) ? HEADER_BYTE : 8'($urandom);
    return t;
  endfunction

  // Let every result out, close any frame left open, and give the block
  // time to go idle before the next register write.
  task automatic settle_idle();
    wait_drained();
    while (dec_collecting) begin
      for (int i = dec_position; i < FRAME_LEN; i++) tx_bytes.push_back(8'($urandom));
      wait_drained();
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  // Mostly well-formed frames with random content, mixed with stray bytes
  // that sometimes include a false header and knock the framing off.
  task automatic random_traffic(input int n);
    int sent;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3))
          tx_bytes.push_back(($urandom_range(0, 3) == 0) ? HEADER_BYTE : 8'($urandom));
      end else begin
        push_frame(random_raws(), 4'($urandom), random_tail());
        sent += FRAME_LEN;
      end
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
  endtask

  initial begin
    logic [NCH*RAW_W-1:0] raws;
    raw_t arm_raw;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    // Top threshold: channel 8 can never reach it.
    write_threshold('1);
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(8'hFF);
    tx_bytes.push_back(8'hA5);
    tx_bytes.push_back(8'h5A);
    for (int k = 0; k < NCH; k++) raws[RAW_W*k +: RAW_W] = (k % 2) ? '1 : '0;
    push_frame(raws, 4'hF, 56'h0F_FF_00_0F_AA_55_0F);
    for (int k = 0; k < NCH; k++) raws[RAW_W*k +: RAW_W] = (k % 2) ? '0 : '1;
    // Channel 1 makes the first data word look like a header.
    raws[RAW_W-1:0] = RAW_W'(HEADER_BYTE);
    push_frame(raws, 4'h0, random_tail());
    settle_idle();

    // Channel 8 just below the threshold, then exactly on it.
    arm_raw = raw_t'($urandom_range(200, 2047));
    write_threshold(to_usec(arm_raw));
    raws = random_raws();
    raws[RAW_W*(ARM_CHANNEL-1) +: RAW_W] = arm_raw - 2;
    push_frame(raws, 4'($urandom), random_tail());
    raws = random_raws();
    raws[RAW_W*(ARM_CHANNEL-1) +: RAW_W] = arm_raw;
    push_frame(raws, 4'($urandom), random_tail());
    settle_idle();

    write_threshold('0);
    random_traffic(25);
    settle_idle();
    write_threshold(val_t'($urandom_range(585, 2413)));
    random_traffic(25);
    settle_idle();

    errors += due_words.size();
    $display("run covered %0d bytes and %0d frames; %0d channel words checked",
             bytes_taken, frames_closed, words_checked);
    $display("offsets latched: %0b, threshold settings: max, exact match, zero, random",
             dec_latched);
    if (errors == 0) begin
      $display("tb_rc_serial_frame_channel_decoder: clean");
    end else begin
      $display("tb_rc_serial_frame_channel_decoder: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/rcsf_pkg.sv
design/rcsf_cell.sv
design/rcsf_collector.sv
design/rc_serial_frame_channel_decoder.sv
tb/tb_rc_serial_frame_channel_decoder.sv
